/* hdl/positional_list_table_top_macros.svh */
// Assertion macros shared by the positional list table RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef POSITIONAL_LIST_TABLE_TOP_MACROS_SVH
`define POSITIONAL_LIST_TABLE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, masked during rst.
`define PLT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("positional list table check failed");

// Next-cycle implication.
`define PLT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("positional list table check failed");

`endif

/* hdl/plt_pkg.sv */
// Package for the positional list table: field widths, opcodes, cell control.
// No dependencies.
package plt_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 8;
  localparam int OP_W      = 3;
  localparam int OUT_CNT_W = 6;   // width of count and found_at on the port

  localparam logic [OP_W-1:0] OP_EMPTY  = 3'd0;
  localparam logic [OP_W-1:0] OP_ZERO   = 3'd1;
  localparam logic [OP_W-1:0] OP_READ   = 3'd2;
  localparam logic [OP_W-1:0] OP_LOCATE = 3'd3;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd4;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd5;

  // Broadcast to every cell; at most one is set per transaction.
  typedef struct packed {
    logic clear;
    logic shift_up;
    logic shift_down;
  } plt_cell_ctrl_t;

endpackage

/* hdl/plt_cell.sv */
// One slot of the list: a 32-bit value register with neighbour shift muxes.
// Depends on plt_pkg.
module plt_cell import plt_pkg::*; #(
  parameter int IDX   = 0,
  parameter int CNT_W = 6
) (
  input  logic                       clk,
  input  plt_cell_ctrl_t             ctrl,
  input  logic [POS_W-1:0]           pos,
  input  logic [CNT_W-1:0]           count,
  input  logic signed [DATA_W-1:0]   new_value,
  input  logic signed [DATA_W-1:0]   left_value,
  input  logic signed [DATA_W-1:0]   right_value,
  output logic signed [DATA_W-1:0]   value,
  output logic signed [DATA_W-1:0]   rd_data,
  output logic                       match
);

  localparam logic [POS_W-1:0] SLOT     = POS_W'(IDX + 1);
  localparam logic [CNT_W-1:0] SLOT_IDX = CNT_W'(IDX);

  logic hit;
  logic at_or_after;

  assign hit         = (pos == SLOT);
  assign at_or_after = (pos != '0) && (pos <= SLOT);

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      value <= '0;
    end else if (ctrl.shift_up && at_or_after) begin
      value <= hit ? new_value : left_value;
    end else if (ctrl.shift_down && at_or_after) begin
      value <= right_value;
    end
  end

  assign rd_data = hit ? value : '0;
  assign match   = (SLOT_IDX < count) && (value == new_value);

endmodule

/* hdl/plt_chain.sv */
// Row of list cells with read-out OR and first-match priority encoder.
// Depends on plt_pkg and plt_cell.
module plt_chain import plt_pkg::*; #(
  parameter int DEPTH   = DEPTH_DEF,
  parameter int CNT_W   = 6
) (
  input  logic                       clk,
  input  plt_cell_ctrl_t             ctrl,
  input  logic [POS_W-1:0]           pos,
  input  logic [CNT_W-1:0]           count,
  input  logic signed [DATA_W-1:0]   new_value,
  output logic signed [DATA_W-1:0]   rd_data,
  output logic [CNT_W-1:0]           found
);

  logic signed [DATA_W-1:0] vals  [DEPTH];
  logic signed [DATA_W-1:0] rds   [DEPTH];
  logic signed [DATA_W-1:0] lefts [DEPTH];
  logic signed [DATA_W-1:0] rights[DEPTH];
  logic [DEPTH-1:0]         match_vec;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    // ends of the row: head's left input is never selected, tail keeps itself
    if (k == 0) begin : g_head
      assign lefts[k] = new_value;
    end else begin : g_left
      assign lefts[k] = vals[k-1];
    end
    if (k == DEPTH - 1) begin : g_tail
      assign rights[k] = vals[k];
    end else begin : g_right
      assign rights[k] = vals[k+1];
    end

    plt_cell #(.IDX(k), .CNT_W(CNT_W)) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .pos        (pos),
      .count      (count),
      .new_value  (new_value),
      .left_value (lefts[k]),
      .right_value(rights[k]),
      .value      (vals[k]),
      .rd_data    (rds[k]),
      .match      (match_vec[k])
    );
  end

  always_comb begin
    rd_data = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rd_data = rd_data | rds[k];
    end
  end

  // lowest matching slot wins; scan from the top so it is written last
  always_comb begin
    found = '0;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if (match_vec[k]) begin
        found = CNT_W'(k + 1);
      end
    end
  end

endmodule

/* hdl/positional_list_table_top.sv */
// Positional list table top: request decode, element count, result register.
// Depends on plt_pkg, plt_chain (plt_cell) and positional_list_table_top_macros.svh.
//
//  channel   dir  tdata fields (lsb first)
//  s_axis    in   operation[2:0] position[10:3] value[42:11], zero pad to 48
//  m_axis    out  ok[0] data_out[32:1] found_at[38:33] count[44:39], pad to 48
//
// The whole operation of a transaction, including shifts across the
// cell row and the locate compare, completes at the accepting edge.
// The result register frees the input side whenever it is empty or being taken.
// rst (synchronous) clears the count and the result valid; cell values are
// left unset and are never reported until written.
`include "positional_list_table_top_macros.svh"

module positional_list_table_top import plt_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // operation, position, value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // ok, data_out, found_at, count
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  logic [OP_W-1:0]          op;
  logic [POS_W-1:0]         pos;
  logic signed [DATA_W-1:0] val;
  logic                     in_acc;

  logic [CNT_W-1:0]         count_q;
  logic [CNT_W-1:0]         count_next;
  logic [CMP_W-1:0]         pos_e;
  logic [CMP_W-1:0]         cnt_e;
  logic                     pos_in_list;
  logic                     pos_append;
  logic                     full;

  plt_cell_ctrl_t           ctrl;
  logic                     ok_c;
  logic signed [DATA_W-1:0] data_c;
  logic [CNT_W-1:0]         found_c;
  logic signed [DATA_W-1:0] chain_rd;
  logic [CNT_W-1:0]         chain_found;
  logic                     ins_ok;

  logic [CNT_W+OUT_CNT_W-1:0] cnt_wide;
  logic [CNT_W+OUT_CNT_W-1:0] found_wide;

  logic                     out_valid;
  logic                     out_ok;
  logic signed [DATA_W-1:0] out_data;
  logic [OUT_CNT_W-1:0]     out_found;
  logic [OUT_CNT_W-1:0]     out_count;

  assign op  = s_axis_tdata[2:0];
  assign pos = s_axis_tdata[10:3];
  assign val = s_axis_tdata[42:11];

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign pos_e       = CMP_W'(pos);
  assign cnt_e       = CMP_W'(count_q);
  assign pos_in_list = (pos != '0) && (pos_e <= cnt_e);
  assign pos_append  = (pos != '0) && (pos_e <= cnt_e + 1'b1);
  assign full        = (count_q == CNT_W'(DEPTH));

  always_comb begin
    ctrl       = '0;
    ok_c       = 1'b0;
    data_c     = '0;
    found_c    = '0;
    count_next = count_q;
    unique case (op)
      OP_EMPTY: begin
        ok_c       = 1'b1;
        count_next = '0;
      end
      OP_ZERO: begin
        ok_c       = 1'b1;
        ctrl.clear = 1'b1;
      end
      OP_READ: begin
        ok_c   = pos_in_list;
        data_c = pos_in_list ? chain_rd : '0;
      end
      OP_LOCATE: begin
        ok_c    = 1'b1;
        found_c = chain_found;
      end
      OP_INSERT: begin
        if (!full && pos_append) begin
          ok_c          = 1'b1;
          ctrl.shift_up = 1'b1;
          count_next    = count_q + 1'b1;
        end
      end
      OP_DELETE: begin
        if (pos_in_list) begin
          ok_c            = 1'b1;
          data_c          = chain_rd;
          ctrl.shift_down = 1'b1;
          count_next      = count_q - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign ins_ok = (op == OP_INSERT) && ok_c;

  plt_chain #(.DEPTH(DEPTH), .CNT_W(CNT_W)) u_chain (
    .clk      (clk),
    .ctrl     (in_acc ? ctrl : plt_cell_ctrl_t'('0)),
    .pos      (pos),
    .count    (count_q),
    .new_value(val),
    .rd_data  (chain_rd),
    .found    (chain_found)
  );

  // port fields are six bits; wider internal counts are masked
  assign cnt_wide   = (CNT_W + OUT_CNT_W)'(count_next);
  assign found_wide = (CNT_W + OUT_CNT_W)'(found_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      count_q   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        count_q   <= count_next;
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_ok    <= ok_c;
      out_data  <= data_c;
      out_found <= found_wide[OUT_CNT_W-1:0];
      out_count <= cnt_wide[OUT_CNT_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_count, out_found, out_data, out_ok};

  `PLT_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH))
  `PLT_ASSERT_NEXT(a_insert_grows, in_acc && ins_ok, count_q == $past(count_q) + 1'b1)
  `PLT_ASSERT_NEXT(a_fail_keeps, in_acc && !ok_c, $stable(count_q))
  `PLT_ASSERT_NEXT(a_result_follows, in_acc, m_axis_tvalid)
  `PLT_ASSERT_IMPL(a_one_action, in_acc, $onehot0(ctrl))

endmodule
